// ===== rtl/icv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icv_pkg
// Shared constants and types for the image CRC-32 verifier.
// ----------------------------------------------------------------------------
package icv_pkg;

  localparam int unsigned SizeW  = 24;
  localparam int unsigned CrcW   = 32;
  localparam int unsigned ByteW  = 8;

  localparam logic [CrcW-1:0]  CrcPoly   = 32'hEDB8_8320;
  localparam logic [CrcW-1:0]  CrcInit   = 32'hFFFF_FFFF;
  localparam logic [SizeW-1:0] SizeReset = 24'd65536;

  // Number of trailing checksum bytes at the end of an image.
  localparam logic [SizeW:0]   TrailerBytes = 25'd4;

  typedef struct packed {
    logic            crc_ok;
    logic [CrcW-1:0] computed_crc;
    logic [CrcW-1:0] stored_crc;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/icv_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icv_if
// Valid/ready channels for image bytes in and check results out.
// ----------------------------------------------------------------------------
interface icv_byte_if;
  logic                         valid;
  logic                         ready;
  logic [icv_pkg::ByteW-1:0]    data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface icv_result_if;
  logic                         valid;
  logic                         ready;
  logic                         crc_ok;
  logic [icv_pkg::CrcW-1:0]     computed_crc;
  logic [icv_pkg::CrcW-1:0]     stored_crc;

  modport source (output valid, output crc_ok, output computed_crc, output stored_crc,
                  input ready);
  modport sink   (input valid, input crc_ok, input computed_crc, input stored_crc,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/icv_crc_byte.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icv_crc_byte
// Folds one byte into a reflected CRC-32 register combinationally.
// ----------------------------------------------------------------------------
module icv_crc_byte (
  input  wire logic [icv_pkg::CrcW-1:0]  crc_i,
  input  wire logic [icv_pkg::ByteW-1:0] byte_i,
  output logic      [icv_pkg::CrcW-1:0]  crc_o
);

  logic [icv_pkg::CrcW-1:0] acc;

  // Eight bit steps of the LSB-first shift register, unrolled.
  always_comb begin
    acc = crc_i ^ {{(icv_pkg::CrcW-icv_pkg::ByteW){1'b0}}, byte_i};
    for (int k = 0; k < icv_pkg::ByteW; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ icv_pkg::CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    crc_o = acc;
  end

endmodule
`default_nettype wire

// ===== rtl/image_crc32_verifier_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// image_crc32_verifier_top
// Streams a firmware image byte by byte, runs CRC-32 over the body and
// compares it against the little-endian checksum in the last four bytes.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake      Beat content
//   in_if     in    valid/ready    data_byte: next image byte in address order
//   out_if    out   valid/ready    crc_ok, computed_crc, stored_crc
//   cfg       in    cfg_we_i       cfg_wdata_i: image size in bytes
//
// Input beats need no wait state; a new byte may follow in the next
// cycle. The only storage between the sides is the result register, so the
// final byte of an image shows its result in the cycle after it is accepted.
// Input ready drops only while a result is held and the sink is not taking it.
// Reset returns the image size to 65536 bytes, presets the running CRC to
// all ones, clears the byte count and trailer word; needs no clearing pass.
//
module image_crc32_verifier_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [icv_pkg::SizeW-1:0]  cfg_wdata_i,
  icv_byte_if.sink                        in_if,
  icv_result_if.source                    out_if
);

  // Configuration register holding the total image length.
  logic [icv_pkg::SizeW-1:0] size_q;

  // Per-image running state.
  logic [icv_pkg::CrcW-1:0]  crc_q,     crc_d;
  logic [icv_pkg::SizeW-1:0] count_q,   count_d;
  logic [icv_pkg::CrcW-1:0]  trailer_q, trailer_d;

  // Result register with its valid flag.
  icv_pkg::result_t          res_q,     res_d;
  logic                      res_vld_q, res_vld_d;

  logic                      in_fire;
  logic                      fold_en;
  logic                      last_byte;
  logic [icv_pkg::SizeW:0]   idx_ext;
  logic [icv_pkg::SizeW:0]   size_ext;
  logic [icv_pkg::CrcW-1:0]  crc_fold;
  logic [icv_pkg::CrcW-1:0]  crc_upd;
  logic [icv_pkg::CrcW-1:0]  trailer_upd;

  // The byte port can accept whenever the result slot is free or draining.
  assign in_if.ready = !res_vld_q || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  icv_crc_byte u_crc_byte (
    .crc_i  (crc_q),
    .byte_i (in_if.data_byte),
    .crc_o  (crc_fold)
  );

  // Index and size are widened by one bit so that the compares never wrap.
  assign idx_ext   = {1'b0, count_q};
  assign size_ext  = {1'b0, size_q};
  assign fold_en   = (idx_ext + icv_pkg::TrailerBytes) < size_ext;
  assign last_byte = (idx_ext + 25'd1) >= size_ext;

  // A body byte goes into the CRC; a trailer byte shifts in from the top.
  assign crc_upd     = fold_en ? crc_fold : crc_q;
  assign trailer_upd = fold_en ? trailer_q : {in_if.data_byte, trailer_q[31:8]};

  always_comb begin
    crc_d     = crc_q;
    count_d   = count_q;
    trailer_d = trailer_q;
    res_d     = res_q;
    res_vld_d = res_vld_q && !out_if.ready;

    if (in_fire) begin
      if (last_byte) begin
        // Image complete: publish the result and start over.
        res_d.computed_crc = ~crc_upd;
        res_d.stored_crc   = trailer_upd;
        res_d.crc_ok       = (~crc_upd) == trailer_upd;
        res_vld_d          = 1'b1;
        crc_d              = icv_pkg::CrcInit;
        count_d            = '0;
        trailer_d          = '0;
      end else begin
        crc_d     = crc_upd;
        trailer_d = trailer_upd;
        count_d   = count_q + 24'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= icv_pkg::SizeReset;
      crc_q     <= icv_pkg::CrcInit;
      count_q   <= '0;
      trailer_q <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      crc_q     <= crc_d;
      count_q   <= count_d;
      trailer_q <= trailer_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Result payload carries no reset; it is qualified by res_vld_q.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_if.valid        = res_vld_q;
  assign out_if.crc_ok       = res_q.crc_ok;
  assign out_if.computed_crc = res_q.computed_crc;
  assign out_if.stored_crc   = res_q.stored_crc;

endmodule
`default_nettype wire

// ===== rtl/icv_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icv_checker
// Port-level assertions for the image CRC-32 verifier.
// ----------------------------------------------------------------------------
module icv_checker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_ready_i,
  input  wire logic                      out_valid_i,
  input  wire logic                      out_ready_i,
  input  wire logic                      crc_ok_i,
  input  wire logic [icv_pkg::CrcW-1:0]  computed_crc_i,
  input  wire logic [icv_pkg::CrcW-1:0]  stored_crc_i
);

  // A held result keeps its payload until the sink takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(crc_ok_i) && $stable(computed_crc_i) && $stable(stored_crc_i))
    else $error("result beat changed while stalled");

  // The pass flag must agree with the two checksums it reports.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> crc_ok_i == (computed_crc_i == stored_crc_i))
    else $error("crc_ok does not match computed and stored CRC");

  // With no result pending the byte port must be open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  // A fresh result can only follow an accepted byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !($past(out_valid_i) && !$past(out_ready_i)) |->
      $past(in_valid_i) && $past(in_ready_i))
    else $error("result beat appeared without an input byte");

endmodule

bind image_crc32_verifier_top icv_checker u_icv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_if.valid),
  .in_ready_i     (in_if.ready),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .crc_ok_i       (out_if.crc_ok),
  .computed_crc_i (out_if.computed_crc),
  .stored_crc_i   (out_if.stored_crc)
);
`default_nettype wire
